// File: sv/rrss_pkg.sv
package rrss_pkg;

  localparam int NUM_TASKS_DEF = 8;

  localparam int CNT_W   = 16;
  localparam int MS_W    = 16;
  localparam int CAUSE_W = 8;
  localparam int TASK_W  = 3;
  localparam int MASK_W  = 8;

  // Elapsed time is floor(count * 20 / compare), which equals the two
  // truncating divisions by compare and by ten applied to count * 200.
  localparam int TICK_SCALE = 20;
  localparam int NUM_W      = 21;
  localparam int DCNT_W     = $clog2(NUM_W);

  localparam logic [15:0] COMPARE_RST = 16'd312;
  localparam logic [15:0] DEFAULT_RST = 16'd20;
  localparam logic [7:0]  DELAY_RST   = 8'd1;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_COMPARE = 2'd0,
    REG_DEFAULT = 2'd1,
    REG_DELAY   = 2'd2
  } reg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_DECR = 5'b00100,
    S_SEL  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    logic [15:0] compare_value;
    logic [15:0] default_period_ms;
    logic [7:0]  delay_reason_code;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic dec_step;
    logic sel_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic skip_div;
    logic div_last;
    logic dec_last;
    logic sel_hit;
    logic sel_last;
  } sts_t;

endpackage

// File: sv/round_robin_sleep_scheduler.sv
// Round-robin task scheduler with sleep timers. One input word is either a
// timer tick or a wait by the running task; every word yields exactly one
// result word with the task chosen to run, a flag for no task awake and the
// mask of tasks woken. Words are handled one at a time: a tick with a non-zero
// timer count first runs the bit-serial divider that works out the elapsed
// milliseconds, and a wait or a tick with a zero count skips the divider. The
// countdown and the selection then each walk the tasks one per cycle. A
// finished word sits in an output register, so the next input word is taken
// while it waits. Configuration is to be written over the APB port only while
// the block is idle; the block itself does not enforce this.
module round_robin_sleep_scheduler import rrss_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [CNT_W-1:0]   elapsed_count_i,
  input  logic [CAUSE_W-1:0] sleep_reason_i,
  input  logic [MS_W-1:0]    sleep_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TASK_W-1:0]  current_task_o,
  output logic               none_ready_o,
  output logic [MASK_W-1:0]  woke_mask_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  rrss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rrss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rrss_dp #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_i           (cfg),
    .opcode_i        (opcode_i),
    .elapsed_count_i (elapsed_count_i),
    .sleep_reason_i  (sleep_reason_i),
    .sleep_ms_i      (sleep_ms_i),
    .current_task_o  (current_task_o),
    .none_ready_o    (none_ready_o),
    .woke_mask_o     (woke_mask_o)
  );

endmodule

// File: sv/rrss_regs.sv
module rrss_regs import rrss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_COMPARE: cfg_d.compare_value     = pwdata[15:0];
        REG_DEFAULT: cfg_d.default_period_ms = pwdata[15:0];
        REG_DELAY:   cfg_d.delay_reason_code = pwdata[7:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COMPARE: prdata = {16'd0, cfg_q.compare_value};
      REG_DEFAULT: prdata = {16'd0, cfg_q.default_period_ms};
      REG_DELAY:   prdata = {24'd0, cfg_q.delay_reason_code};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.compare_value     <= COMPARE_RST;
      cfg_q.default_period_ms <= DEFAULT_RST;
      cfg_q.delay_reason_code <= DELAY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/rrss_ctrl.sv
module rrss_ctrl import rrss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.skip_div ? S_DECR : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DECR;
        end
      end
      S_DECR: begin
        cmd_o.dec_step = 1'b1;
        if (sts_i.dec_last) begin
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        cmd_o.sel_step = 1'b1;
        if (sts_i.sel_hit || sts_i.sel_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DIV || state_q == S_DECR))
    else $error("accepted word did not start work");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && out_stall_i) |=> (state_q == S_DONE))
    else $error("result overwrote a stalled word");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !(out_valid_q && out_stall_i)) |=>
      (out_valid_q && state_q == S_IDLE))
    else $error("finished result was not presented");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");
`endif

endmodule

// File: sv/rrss_dp.sv
module rrss_dp import rrss_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  cfg_t               cfg_i,
  input  logic               opcode_i,
  input  logic [CNT_W-1:0]   elapsed_count_i,
  input  logic [CAUSE_W-1:0] sleep_reason_i,
  input  logic [MS_W-1:0]    sleep_ms_i,
  output logic [TASK_W-1:0]  current_task_o,
  output logic               none_ready_o,
  output logic [MASK_W-1:0]  woke_mask_o
);

  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int XW = (IW > TASK_W) ? IW : TASK_W;
  localparam int WW = (NUM_TASKS > MASK_W) ? NUM_TASKS : MASK_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TASKS - 1);

  logic [NUM_TASKS-1:0] asleep_q, asleep_d;
  logic [CAUSE_W-1:0]   cause_q [NUM_TASKS];
  logic [CAUSE_W-1:0]   cause_d [NUM_TASKS];
  logic [MS_W-1:0]      rem_q [NUM_TASKS];
  logic [MS_W-1:0]      rem_d [NUM_TASKS];
  logic [IW-1:0]        run_q, run_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [NUM_TASKS-1:0] woke_q, woke_d;
  logic                 none_q, none_d;
  logic                 use_def_q, use_def_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic [MS_W-1:0]      part_q, part_d;
  logic [DCNT_W-1:0]    dcnt_q, dcnt_d;
  logic [TASK_W-1:0]    cur_out_q, cur_out_d;
  logic                 none_out_q, none_out_d;
  logic [MASK_W-1:0]    woke_out_q, woke_out_d;

  logic [MS_W-1:0]   divisor;
  logic [MS_W:0]     trial;
  logic              ge;
  logic [NUM_W-1:0]  elapsed;
  logic [NUM_W-1:0]  rem_ext;
  logic [MS_W-1:0]   rem_new;
  logic [NUM_W-1:0]  count_ext;
  logic [XW-1:0]     run_ext;
  logic [WW-1:0]     woke_ext;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
    return (v == LAST_IDX) ? '0 : IW'(v + 1'b1);
  endfunction

  assign divisor   = (cfg_i.compare_value == '0) ? MS_W'(1) : cfg_i.compare_value;
  assign trial     = {part_q, num_q[NUM_W-1]};
  assign ge        = (trial >= {1'b0, divisor});
  assign elapsed   = use_def_q ? NUM_W'(cfg_i.default_period_ms) : num_q;
  assign rem_ext   = NUM_W'(rem_q[idx_q]);
  assign rem_new   = (rem_ext > elapsed) ? MS_W'(rem_ext - elapsed) : '0;
  assign count_ext = NUM_W'(elapsed_count_i);

  assign sts_o.skip_div = opcode_i | (elapsed_count_i == '0);
  assign sts_o.div_last = (dcnt_q == DCNT_W'(NUM_W - 1));
  assign sts_o.dec_last = (idx_q == LAST_IDX);
  assign sts_o.sel_hit  = !asleep_q[idx_q];
  assign sts_o.sel_last = (idx_q == run_q);

  always_comb begin
    asleep_d   = asleep_q;
    cause_d    = cause_q;
    rem_d      = rem_q;
    run_d      = run_q;
    idx_d      = idx_q;
    woke_d     = woke_q;
    none_d     = none_q;
    use_def_d  = use_def_q;
    num_d      = num_q;
    part_d     = part_q;
    dcnt_d     = dcnt_q;
    cur_out_d  = cur_out_q;
    none_out_d = none_out_q;
    woke_out_d = woke_out_q;

    if (cmd_i.load) begin
      use_def_d = sts_o.skip_div;
      num_d     = count_ext * NUM_W'(TICK_SCALE);
      part_d    = '0;
      dcnt_d    = '0;
      idx_d     = '0;
      woke_d    = '0;
      if (opcode_i) begin
        asleep_d[run_q] = 1'b1;
        cause_d[run_q]  = sleep_reason_i;
        rem_d[run_q]    = sleep_ms_i;
      end
    end

    if (cmd_i.div_step) begin
      part_d = ge ? MS_W'(trial - {1'b0, divisor}) : MS_W'(trial);
      num_d  = {num_q[NUM_W-2:0], ge};
      dcnt_d = DCNT_W'(dcnt_q + 1'b1);
    end

    if (cmd_i.dec_step) begin
      if (asleep_q[idx_q] && cause_q[idx_q] == cfg_i.delay_reason_code) begin
        rem_d[idx_q] = rem_new;
        if (rem_new == '0) begin
          asleep_d[idx_q] = 1'b0;
          woke_d[idx_q]   = 1'b1;
        end
      end
      idx_d = sts_o.dec_last ? wrap_inc(run_q) : wrap_inc(idx_q);
    end

    if (cmd_i.sel_step) begin
      priority if (sts_o.sel_hit) begin
        run_d  = idx_q;
        none_d = 1'b0;
      end else if (sts_o.sel_last) begin
        none_d = 1'b1;
      end else begin
        idx_d = wrap_inc(idx_q);
      end
    end

    if (cmd_i.out_load) begin
      cur_out_d  = run_ext[TASK_W-1:0];
      none_out_d = none_q;
      woke_out_d = woke_ext[MASK_W-1:0];
    end
  end

  assign run_ext  = XW'(run_q);
  assign woke_ext = WW'(woke_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asleep_q <= '0;
      run_q    <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        cause_q[i] <= '0;
        rem_q[i]   <= '0;
      end
    end else begin
      asleep_q <= asleep_d;
      run_q    <= run_d;
      cause_q  <= cause_d;
      rem_q    <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    woke_q     <= woke_d;
    none_q     <= none_d;
    use_def_q  <= use_def_d;
    num_q      <= num_d;
    part_q     <= part_d;
    dcnt_q     <= dcnt_d;
    cur_out_q  <= cur_out_d;
    none_out_q <= none_out_d;
    woke_out_q <= woke_out_d;
  end

  assign current_task_o = cur_out_q;
  assign none_ready_o   = none_out_q;
  assign woke_mask_o    = woke_out_q;

`ifndef SYNTHESIS
  a_pick_awake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sel_step && sts_o.sel_hit) |=> !asleep_q[run_q])
    else $error("selected task is asleep");

  a_none_means_all_asleep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sel_step && !sts_o.sel_hit && sts_o.sel_last) |=> (&asleep_q))
    else $error("no task reported awake while one is");

  a_woken_awake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sel_step |-> ((woke_q & asleep_q) == '0))
    else $error("woken task still marked asleep");
`endif

endmodule
